// ===== hw/rtl/e2q_pkg.sv =====
// Shared constants, types and helper functions for the Euler angle to quaternion block.
`default_nettype none

package e2q_pkg;

  // Field widths and fixed-point formats.
  localparam int ANGLE_WIDTH     = 16;
  localparam int RESULT_FRACTION = 14;
  localparam int OUT_WIDTH       = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int CW              = 32;   // CORDIC x, y and z width (Q30 for x and y)
  localparam int PW              = 64;   // full product width
  localparam int SW              = 65;   // width of a sum of two products
  localparam int NUM_ANGLES      = 3;
  localparam int IDX_ROLL        = 0;
  localparam int IDX_PITCH       = 1;
  localparam int IDX_YAW         = 2;
  localparam int PIPE_DEPTH      = CORDIC_STEPS + 3;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Arctangent of 2^-i in 2^32-per-turn units.
  function automatic logic signed [CW-1:0] atan_lut(input int i);
    logic signed [CW-1:0] v;
    unique case (i)
      0:  v = 32'sh20000000;  1:  v = 32'sh12E4051E;  2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;  4:  v = 32'sh028B0D43;  5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;  7:  v = 32'sh00517C55;  8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2F;  10: v = 32'sh000A2F98;  11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;  13: v = 32'sh000145F3;  14: v = 32'sh0000A2FA;
      15: v = 32'sh0000517D;  16: v = 32'sh000028BE;  17: v = 32'sh0000145F;
      18: v = 32'sh00000A30;  19: v = 32'sh00000518;  20: v = 32'sh0000028C;
      21: v = 32'sh00000146;  22: v = 32'sh000000A3;  23: v = 32'sh00000051;
      24: v = 32'sh00000029;  25: v = 32'sh00000014;  26: v = 32'sh0000000A;
      27: v = 32'sh00000005;  28: v = 32'sh00000003;  29: v = 32'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Starting point of the rotation: half angle on a 32-bit circle, unit vector scaled by K.
  function automatic cordic_t cordic_init(input logic signed [ANGLE_WIDTH-1:0] a);
    cordic_t c;
    logic signed [CW-1:0] full;
    full = {a, {(CW-ANGLE_WIDTH){1'b0}}};
    c.x = CORDIC_GAIN;
    c.y = '0;
    c.z = full >>> 1;
    return c;
  endfunction

  // One rotation step with arithmetic shifts.
  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.z[CW-1]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - atan_lut(i);
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + atan_lut(i);
    end
    return n;
  endfunction

  // Round a Q60 product back to Q30.
  function automatic logic signed [CW-1:0] round_q30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + (64'sd1 <<< 29)) >>> 30;
    return r[CW-1:0];
  endfunction

  // Round a Q60 sum to the result fraction and clamp to plus or minus one.
  function automatic logic [OUT_WIDTH-1:0] finish(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] lim;
    lim = 65'sd1 <<< RESULT_FRACTION;
    v = (s + (65'sd1 <<< (59 - RESULT_FRACTION))) >>> (60 - RESULT_FRACTION);
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v[OUT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/euler_to_quaternion_top.sv =====
// Pipelined Z-Y-X Euler angle to unit quaternion converter.
//
// Input channel: in_valid / in_ready carry one beat of roll, pitch and yaw as
// signed binary angles (half the code range is pi radians).
// Output channel: out_valid / out_ready carry one beat of the quaternion
// w, x, y, z in signed Q1.14, each clamped to plus or minus 16384.
// The pipeline has thirty unrolled CORDIC rotation stages that run the
// three half angles side by side, one stage of four 32x32 half-products, one
// stage of eight 32x32 triple-products, and a round, clamp and output stage.
// Throughput is one beat per cycle while the receiver keeps out_ready high.
// The whole pipeline advances on one shared enable; when the receiver stalls
// with a result waiting, every stage holds and in_ready drops, so nothing is
// lost or repeated. Empty stages never hold up the pipeline.
// Reset clears only the per-stage valid bits; the data registers are not reset.
`default_nettype none

module euler_to_quaternion_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic signed [e2q_pkg::ANGLE_WIDTH-1:0] in_roll_angle,
  input  wire logic signed [e2q_pkg::ANGLE_WIDTH-1:0] in_pitch_angle,
  input  wire logic signed [e2q_pkg::ANGLE_WIDTH-1:0] in_yaw_angle,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic signed [e2q_pkg::OUT_WIDTH-1:0]   out_quat_w,
  output      logic signed [e2q_pkg::OUT_WIDTH-1:0]   out_quat_x,
  output      logic signed [e2q_pkg::OUT_WIDTH-1:0]   out_quat_y,
  output      logic signed [e2q_pkg::OUT_WIDTH-1:0]   out_quat_z
);
  import e2q_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  adv;

  cordic_t cs_r [CORDIC_STEPS][NUM_ANGLES];

  logic signed [CW-1:0] cos_r [NUM_ANGLES];
  logic signed [CW-1:0] sin_r [NUM_ANGLES];

  // Half-product stage.
  logic signed [PW-1:0] p_cc_r, p_ss_r, p_sc_r, p_cs_r;
  logic signed [CW-1:0] cy_r, sy_r;
  logic signed [CW-1:0] ab_cc, ab_ss, ab_sc, ab_cs;

  // Triple-product stage.
  logic signed [PW-1:0] t_w0_r, t_w1_r, t_x0_r, t_x1_r;
  logic signed [PW-1:0] t_y0_r, t_y1_r, t_z0_r, t_z1_r;

  logic signed [OUT_WIDTH-1:0] qw_r, qx_r, qy_r, qz_r;

  logic signed [ANGLE_WIDTH-1:0] ang [NUM_ANGLES];

  // The pipeline moves when the output register is empty or being drained.
  assign adv       = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[PIPE_DEPTH-1];

  assign ang[IDX_ROLL]  = in_roll_angle;
  assign ang[IDX_PITCH] = in_pitch_angle;
  assign ang[IDX_YAW]   = in_yaw_angle;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Unrolled CORDIC rotation, one step per stage, three angles in parallel.
  for (genvar a = 0; a < NUM_ANGLES; a++) begin : g_ang
    always_ff @(posedge clk) begin
      if (adv) begin
        cs_r[0][a] <= cordic_step(cordic_init(ang[a]), 0);
      end
    end
    for (genvar s = 1; s < CORDIC_STEPS; s++) begin : g_step
      always_ff @(posedge clk) begin
        if (adv) begin
          cs_r[s][a] <= cordic_step(cs_r[s-1][a], s);
        end
      end
    end
    assign cos_r[a] = cs_r[CORDIC_STEPS-1][a].x;
    assign sin_r[a] = cs_r[CORDIC_STEPS-1][a].y;
  end

  // Roll times pitch products; yaw terms ride along.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc_r <= cos_r[IDX_ROLL] * cos_r[IDX_PITCH];
      p_ss_r <= sin_r[IDX_ROLL] * sin_r[IDX_PITCH];
      p_sc_r <= sin_r[IDX_ROLL] * cos_r[IDX_PITCH];
      p_cs_r <= cos_r[IDX_ROLL] * sin_r[IDX_PITCH];
      cy_r   <= cos_r[IDX_YAW];
      sy_r   <= sin_r[IDX_YAW];
    end
  end

  assign ab_cc = round_q30(p_cc_r);
  assign ab_ss = round_q30(p_ss_r);
  assign ab_sc = round_q30(p_sc_r);
  assign ab_cs = round_q30(p_cs_r);

  // Multiply by the yaw terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      t_w0_r <= ab_cc * cy_r;
      t_w1_r <= ab_ss * sy_r;
      t_x0_r <= ab_sc * cy_r;
      t_x1_r <= ab_cs * sy_r;
      t_y0_r <= ab_cs * cy_r;
      t_y1_r <= ab_sc * sy_r;
      t_z0_r <= ab_cc * sy_r;
      t_z1_r <= ab_ss * cy_r;
    end
  end

  // Combine, round and clamp into the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      qw_r <= finish(SW'(t_w0_r) + SW'(t_w1_r));
      qx_r <= finish(SW'(t_x0_r) - SW'(t_x1_r));
      qy_r <= finish(SW'(t_y0_r) + SW'(t_y1_r));
      qz_r <= finish(SW'(t_z0_r) - SW'(t_z1_r));
    end
  end

  assign out_quat_w = qw_r;
  assign out_quat_x = qx_r;
  assign out_quat_y = qy_r;
  assign out_quat_z = qz_r;

endmodule

`default_nettype wire
